/* hw/rtl/skf_pkg.sv */
package skf_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned GainW    = FracBits + 1;
  localparam int unsigned DenW     = DataW + 1;
  localparam int unsigned AccW     = DataW + 2;
  localparam int unsigned ProdW    = AccW + GainW;
  localparam int unsigned XW       = ProdW - FracBits + 1;
  localparam int unsigned CntW     = $clog2(GainW);
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned InTdataW  = ((DataW + 7) / 8) * 8;
  localparam int unsigned OutFieldW = DataW + GainW + DataW;
  localparam int unsigned OutTdataW = ((OutFieldW + 7) / 8) * 8;

  localparam logic [GainW-1:0] GainOne = GainW'(1) << FracBits;

  // register map
  localparam logic [CfgAddrW-1:0] CfgProcNoise = CfgAddrW'(0);
  localparam logic [CfgAddrW-1:0] CfgMeasNoise = CfgAddrW'(1);
  localparam logic [CfgAddrW-1:0] CfgInitCov   = CfgAddrW'(2);
  localparam logic [CfgAddrW-1:0] CfgInitEst   = CfgAddrW'(3);

  localparam logic [DataW-1:0] RstProcNoise = DataW'(6554);
  localparam logic [DataW-1:0] RstMeasNoise = DataW'(6554);
  localparam logic [DataW-1:0] RstInitCov   = DataW'(72090);
  localparam logic [DataW-1:0] RstInitEst   = DataW'(6554);

endpackage

/* hw/rtl/skf_div.sv */
module skf_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [skf_pkg::DataW-1:0]       num_i,
  input  logic [skf_pkg::DenW-1:0]        den_i,
  output logic                            done_o,
  output logic [skf_pkg::GainW-1:0]       quot_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [skf_pkg::CntW-1:0]      cnt_q, cnt_d;
  logic [skf_pkg::AccW-1:0]      rem_q, rem_d;
  logic [skf_pkg::DenW-1:0]      den_q, den_d;
  logic [skf_pkg::GainW-1:0]     quot_q, quot_d;
  logic [skf_pkg::AccW:0]        sub;
  logic                          ge;
  logic [skf_pkg::AccW-1:0]      rem_keep;

  // one quotient bit per cycle, numerator never exceeds the divisor
  assign sub      = {1'b0, rem_q} - {2'b00, den_q};
  assign ge       = ~sub[skf_pkg::AccW];
  assign rem_keep = ge ? sub[skf_pkg::AccW-1:0] : rem_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = skf_pkg::CntW'(skf_pkg::GainW - 1);
      rem_d  = {2'b00, num_i};
      den_d  = den_i;
    end else if (busy_q) begin
      quot_d = {quot_q[skf_pkg::GainW-2:0], ge};
      rem_d  = {rem_keep[skf_pkg::AccW-2:0], 1'b0};
      cnt_d  = cnt_q - skf_pkg::CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

/* hw/rtl/skf_mul.sv */
module skf_mul (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [skf_pkg::AccW-1:0]        mcand_i,
  input  logic [skf_pkg::GainW-1:0]       mplier_i,
  output logic                            done_o,
  output logic [skf_pkg::ProdW-1:0]       prod_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [skf_pkg::CntW-1:0]      cnt_q, cnt_d;
  logic [skf_pkg::AccW-1:0]      mcand_q, mcand_d;
  logic [skf_pkg::AccW-1:0]      hi_q, hi_d;
  logic [skf_pkg::GainW-1:0]     lo_q, lo_d;
  logic [skf_pkg::AccW:0]        sum;

  // signed multiplicand, unsigned multiplier scanned lsb first;
  // product bits shift down into the multiplier register
  assign sum = {hi_q[skf_pkg::AccW-1], hi_q}
             + (lo_q[0] ? {mcand_q[skf_pkg::AccW-1], mcand_q} : '0);

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    mcand_d = mcand_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = skf_pkg::CntW'(skf_pkg::GainW - 1);
      mcand_d = mcand_i;
      hi_d    = '0;
      lo_d    = mplier_i;
    end else if (busy_q) begin
      hi_d  = sum[skf_pkg::AccW:1];
      lo_d  = {sum[0], lo_q[skf_pkg::GainW-1:1]};
      cnt_d = cnt_q - skf_pkg::CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
    hi_q    <= hi_d;
    lo_q    <= lo_d;
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

/* hw/rtl/scalar_kalman_filter.sv */
// each measurement passes through the states S_PRED, S_DIV, S_MUL and S_FIN,
// using the bit-serial divider (17 steps) followed by the two bit-serial
//   multipliers (17 steps)
// one measurement in flight; the result register lets the next one start
// reset: async active low, noise registers and state return to their defaults
module scalar_kalman_filter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [skf_pkg::InTdataW-1:0]      s_axis_tdata,  // measurement
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [skf_pkg::OutTdataW-1:0]     m_axis_tdata,  // estimate, gain, error_cov, zero pad
  input  logic                              cfg_we_i,
  input  logic [skf_pkg::CfgAddrW-1:0]      cfg_addr_i,
  input  logic [skf_pkg::DataW-1:0]         cfg_wdata_i
);

  localparam int unsigned DataW = skf_pkg::DataW;
  localparam int unsigned GainW = skf_pkg::GainW;
  localparam int unsigned XW    = skf_pkg::XW;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PRED = 5'b00010,
    S_DIV  = 5'b00100,
    S_MUL  = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [DataW-1:0]          q_q, r_q;
  logic [DataW-1:0]          est_q, cov_q;
  logic [DataW-1:0]          meas_q;
  logic [DataW-1:0]          p_q;
  logic [DataW:0]            diff_q;
  logic                      den_zero_q;
  logic [GainW-1:0]          k_q;
  logic                      out_valid_q;
  logic [skf_pkg::OutFieldW-1:0] out_q;

  logic                      in_xfer;
  logic [DataW:0]            p_sum;
  logic [DataW-1:0]          p_pred;
  logic [skf_pkg::DenW-1:0]  den;
  logic [DataW:0]            diff;
  logic                      div_start, div_done;
  logic [GainW-1:0]          quot;
  logic [GainW-1:0]          k_next;
  logic                      mul_start, mul_x_done, mul_p_done;
  logic [skf_pkg::ProdW-1:0] prod_x, prod_p;
  logic [XW-1:0]             x_sum;
  logic [DataW-1:0]          x_sat;
  logic [DataW-1:0]          cov_new;
  logic                      out_free;
  logic                      fin_load;

  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  // predicted covariance, saturating at the top
  assign p_sum  = {1'b0, cov_q} + {1'b0, q_q};
  assign p_pred = p_sum[DataW] ? '1 : p_sum[DataW-1:0];
  assign den    = {1'b0, p_pred} + {1'b0, r_q};
  assign diff   = {meas_q[DataW-1], meas_q} - {est_q[DataW-1], est_q};

  assign div_start = (state_q == S_PRED);
  assign k_next    = den_zero_q ? skf_pkg::GainOne : quot;
  assign mul_start = (state_q == S_DIV) && div_done;

  skf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (p_pred),
    .den_i   (den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  skf_mul u_mul_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  ({diff_q[DataW], diff_q}),
    .mplier_i (k_next),
    .done_o   (mul_x_done),
    .prod_o   (prod_x)
  );

  skf_mul u_mul_p (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  ({2'b00, p_q}),
    .mplier_i (skf_pkg::GainOne - k_next),
    .done_o   (mul_p_done),
    .prod_o   (prod_p)
  );

  // arithmetic shift of the product floors toward minus infinity
  assign x_sum = {{(XW - DataW){est_q[DataW-1]}}, est_q}
               + {prod_x[skf_pkg::ProdW-1], prod_x[skf_pkg::ProdW-1:skf_pkg::FracBits]};

  always_comb begin
    x_sat = x_sum[DataW-1:0];
    if (x_sum[XW-1:DataW-1] != '0 && x_sum[XW-1:DataW-1] != '1) begin
      x_sat = x_sum[XW-1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end
  end

  assign cov_new  = prod_p[skf_pkg::FracBits+DataW-1:skf_pkg::FracBits];
  assign out_free = !out_valid_q || m_axis_tready;
  assign fin_load = (state_q == S_FIN) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_xfer) state_d = S_PRED;
      S_PRED: state_d = S_DIV;
      S_DIV:  if (div_done) state_d = S_MUL;
      S_MUL:  if (mul_x_done && mul_p_done) state_d = S_FIN;
      S_FIN:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      q_q         <= skf_pkg::RstProcNoise;
      r_q         <= skf_pkg::RstMeasNoise;
      cov_q       <= skf_pkg::RstInitCov;
      est_q       <= skf_pkg::RstInitEst;
    end else begin
      state_q <= state_d;
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (fin_load) begin
        est_q <= x_sat;
        cov_q <= cov_new;
      end else if (cfg_we_i) begin
        unique case (cfg_addr_i)
          skf_pkg::CfgProcNoise: q_q   <= cfg_wdata_i;
          skf_pkg::CfgMeasNoise: r_q   <= cfg_wdata_i;
          skf_pkg::CfgInitCov:   cov_q <= cfg_wdata_i;
          skf_pkg::CfgInitEst:   est_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      meas_q <= s_axis_tdata[DataW-1:0];
    end
    if (state_q == S_PRED) begin
      p_q        <= p_pred;
      diff_q     <= diff;
      den_zero_q <= (den == '0);
    end
    if (mul_start) begin
      k_q <= k_next;
    end
    if (fin_load) begin
      out_q <= {cov_new, k_q, x_sat};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(skf_pkg::OutTdataW - skf_pkg::OutFieldW){1'b0}}, out_q};

endmodule

/* hw/rtl/skf_checker.sv */
module skf_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [skf_pkg::OutTdataW-1:0]     m_axis_tdata
);

  localparam int unsigned GainLo = skf_pkg::DataW;
  localparam int unsigned GainHi = skf_pkg::DataW + skf_pkg::GainW - 1;
  localparam int unsigned CovLo  = GainHi + 1;
  localparam int unsigned CovHi  = CovLo + skf_pkg::DataW - 1;

  logic [skf_pkg::GainW-1:0] gain;
  logic [skf_pkg::DataW-1:0] cov;
  logic                      in_xfer;

  assign gain    = m_axis_tdata[GainHi:GainLo];
  assign cov     = m_axis_tdata[CovHi:CovLo];
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one measurement at a time: no new transfer right after one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready)
    else $error("input taken while busy");

  // gain never exceeds one
  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> gain <= skf_pkg::GainOne)
    else $error("gain above one");

  // full gain leaves no covariance
  a_gain_one_cov: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && gain == skf_pkg::GainOne |-> cov == '0)
    else $error("covariance not zero at unit gain");

  // no result can appear right after an input transfer
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result too early");

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (.*);
